FILE: hw/rtl/aho_corasick_matcher_top_macros.svh
// ---------------------------------------------------------------------------
// aho_corasick_matcher_top_macros.svh
// assertion macros used by the matcher rtl (acm_back)
// ---------------------------------------------------------------------------
`ifndef AHO_CORASICK_MATCHER_TOP_MACROS_SVH
`define AHO_CORASICK_MATCHER_TOP_MACROS_SVH

// same-cycle implication
`define ACM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acm assertion violated");

// next-cycle implication
`define ACM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acm assertion violated");

`endif

FILE: hw/rtl/acm_pkg.sv
// ---------------------------------------------------------------------------
// acm_pkg
// types, constants and helpers for the aho-corasick matcher
// ---------------------------------------------------------------------------
package acm_pkg;

    localparam int MAX_NODES = 4096;
    localparam int ALPHABET  = 26;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = NODE_W + 1;
    localparam int SYM_W     = 5;
    localparam int TAB_DEPTH = MAX_NODES * ALPHABET;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int WGT_W     = 16;
    localparam int SUM_W     = 32;

    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_END     = 3'd1;
    localparam logic [2:0] REQ_MATCH   = 3'd2;
    localparam logic [2:0] REQ_RESTART = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_INS_REPORT,
        OP_END,
        OP_MATCH,
        OP_MATCH_RESET,
        OP_RESTART,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_VAL,
        S_INS_CHK,
        S_END_WR,
        S_MATCH_SUM,
        S_MATCH_OUT,
        S_RB_INIT,
        S_RB_POP,
        S_RB_U,
        S_RB_LU,
        S_RB_C,
        S_RB_W,
        S_RB_V,
        S_RB_SUM
    } back_state_t;

    typedef struct packed {
        op_t                      op;
        logic [SYM_W-1:0]         symbol;
        logic signed [WGT_W-1:0]  weight;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] val;
        logic                    hit;
    } clamp_t;

    function automatic logic [TAB_AW-1:0] tab_addr(input logic [NODE_W-1:0] n,
                                                   input logic [SYM_W-1:0] s);
        tab_addr = TAB_AW'(n) * TAB_AW'(ALPHABET) + TAB_AW'(s);
    endfunction

    function automatic clamp_t clamp_sum(input logic [SUM_W:0] v);
        clamp_t r;
        if (v[SUM_W] != v[SUM_W-1])
        begin
            r.hit = 1'b1;
            r.val = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            r.hit = 1'b0;
            r.val = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/acm_front.sv
// ---------------------------------------------------------------------------
// acm_front
// accepts request words, classifies them and hands them to the queue
// ---------------------------------------------------------------------------
module acm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    req_type,
    input  logic [acm_pkg::SYM_W-1:0]     symbol,
    input  logic signed [acm_pkg::WGT_W-1:0] weight,
    input  acm_pkg::q_stat_t              q_stat,
    output logic                          push,
    output acm_pkg::item_t                push_item
);
    import acm_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    item_t cls;
    logic  accept;
    logic  sym_ok;

    assign sym_ok = symbol < SYM_W'(ALPHABET);

    always_comb
    begin
        cls.symbol = symbol;
        cls.weight = weight;
        unique case (req_type)
            REQ_INSERT:  cls.op = sym_ok ? OP_INSERT : OP_INS_REPORT;
            REQ_END:     cls.op = OP_END;
            REQ_MATCH:   cls.op = sym_ok ? OP_MATCH : OP_MATCH_RESET;
            REQ_RESTART: cls.op = OP_RESTART;
            REQ_CLEAR:   cls.op = OP_CLEAR;
            default:     cls.op = OP_NOP;
        endcase
    end

    assign busy      = valid_reg && q_stat.full;
    assign push      = valid_reg && !q_stat.full;
    assign accept    = start && !busy;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = cls;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

FILE: hw/rtl/acm_queue.sv
// ---------------------------------------------------------------------------
// acm_queue
// two-word queue between the front and the back
// ---------------------------------------------------------------------------
module acm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  acm_pkg::item_t    push_item,
    input  logic              pop,
    output acm_pkg::item_t    head_item,
    output acm_pkg::q_stat_t  q_stat
);
    import acm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign q_stat.full  = cnt_reg == 2'd2;
    assign q_stat.empty = cnt_reg == 2'd0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/acm_back.sv
// ---------------------------------------------------------------------------
// acm_back
// trie tables, automaton rebuild sequencer and result register
// ---------------------------------------------------------------------------
`include "aho_corasick_matcher_top_macros.svh"

module acm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  acm_pkg::q_stat_t                  q_stat,
    input  acm_pkg::item_t                    q_item,
    output logic                              pop,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [acm_pkg::NODE_W-1:0]        node,
    output logic signed [acm_pkg::SUM_W-1:0]  match_weight
);
    import acm_pkg::*;

    // memories
    logic [NODE_W-1:0] child_mem  [TAB_DEPTH];
    logic [NODE_W-1:0] goto_mem   [TAB_DEPTH];
    logic [NODE_W-1:0] link_mem   [MAX_NODES];
    logic [NODE_W-1:0] parent_mem [MAX_NODES];
    logic [SYM_W-1:0]  letter_mem [MAX_NODES];
    logic [SUM_W-1:0]  nwgt_mem   [MAX_NODES];
    logic [SUM_W:0]    wsum_mem   [MAX_NODES];
    logic [NODE_W-1:0] bfsq_mem   [MAX_NODES];

    logic              child_we, goto_we, link_we, parent_we, letter_we;
    logic              nwgt_we, wsum_we, bfsq_we;
    logic [TAB_AW-1:0] child_waddr, child_raddr, goto_waddr, goto_raddr;
    logic [NODE_W-1:0] child_wdata, child_rdata, goto_wdata, goto_rdata;
    logic [NODE_W-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
    logic [NODE_W-1:0] parent_waddr, parent_raddr, parent_wdata, parent_rdata;
    logic [NODE_W-1:0] letter_waddr, letter_raddr;
    logic [SYM_W-1:0]  letter_wdata, letter_rdata;
    logic [NODE_W-1:0] nwgt_waddr, nwgt_raddr;
    logic [SUM_W-1:0]  nwgt_wdata, nwgt_rdata;
    logic [NODE_W-1:0] wsum_waddr, wsum_raddr;
    logic [SUM_W:0]    wsum_wdata, wsum_rdata;
    logic [NODE_W-1:0] bfsq_waddr, bfsq_raddr, bfsq_wdata, bfsq_rdata;

    back_state_t state_reg, state_next;
    op_t               op_reg, op_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic signed [WGT_W-1:0] wgt_reg, wgt_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic [NODE_W-1:0] match_reg, match_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic              derived_reg, derived_next;
    logic [SUM_W-1:0]  root_w_reg, root_w_next;
    logic [NODE_W-1:0] w_reg, w_next;
    logic [NODE_W-1:0] via_reg, via_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [NODE_W-1:0] lu_reg, lu_next;
    logic [SYM_W-1:0]  c_reg, c_next;
    logic [COUNT_W-1:0] rb_head_reg, rb_head_next;
    logic [COUNT_W-1:0] rb_tail_reg, rb_tail_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [SUM_W-1:0]  mw_reg, mw_next;

    logic   ins_hit, rb_hit, c_last, rb_empty;
    logic [SUM_W-1:0] end_base, rb_add;
    clamp_t end_cl, rb_cl;

    assign ins_hit  = (w_reg != '0) && ({1'b0, w_reg} < count_reg)
                      && (parent_rdata == cursor_reg) && (letter_rdata == sym_reg);
    assign rb_hit   = (w_reg != '0) && ({1'b0, w_reg} < count_reg)
                      && (parent_rdata == u_reg) && (letter_rdata == c_reg);
    assign c_last   = c_reg == SYM_W'(ALPHABET - 1);
    assign rb_empty = rb_head_reg == rb_tail_reg;
    assign end_base = (cursor_reg == '0) ? root_w_reg : nwgt_rdata;
    assign end_cl   = clamp_sum({end_base[SUM_W-1], end_base}
                                + {{(SUM_W-WGT_W+1){wgt_reg[WGT_W-1]}}, wgt_reg});
    assign rb_add   = (via_reg == '0) ? '0 : wsum_rdata[SUM_W-1:0];
    assign rb_cl    = clamp_sum({nwgt_rdata[SUM_W-1], nwgt_rdata}
                                + {rb_add[SUM_W-1], rb_add});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (!q_stat.empty) state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_INSERT: state_next = S_INS_VAL;
                    OP_END:    state_next = S_END_WR;
                    OP_MATCH:  state_next = derived_reg ? S_MATCH_SUM : S_RB_INIT;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_INS_VAL:   state_next = S_INS_CHK;
            S_INS_CHK:   state_next = S_IDLE;
            S_END_WR:    state_next = S_IDLE;
            S_MATCH_SUM: state_next = S_MATCH_OUT;
            S_MATCH_OUT: state_next = S_IDLE;
            S_RB_INIT:   state_next = S_RB_POP;
            S_RB_POP:    state_next = rb_empty ? S_DECODE : S_RB_U;
            S_RB_U:      state_next = S_RB_LU;
            S_RB_LU:     state_next = S_RB_C;
            S_RB_C:      state_next = S_RB_W;
            S_RB_W:      state_next = S_RB_V;
            S_RB_V:
            begin
                if (rb_hit)
                    state_next = S_RB_SUM;
                else
                    state_next = c_last ? S_RB_POP : S_RB_C;
            end
            S_RB_SUM:    state_next = c_last ? S_RB_POP : S_RB_C;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop          = 1'b0;
        child_we     = 1'b0; child_waddr  = '0; child_wdata  = '0; child_raddr  = '0;
        goto_we      = 1'b0; goto_waddr   = '0; goto_wdata   = '0; goto_raddr   = '0;
        link_we      = 1'b0; link_waddr   = '0; link_wdata   = '0; link_raddr   = '0;
        parent_we    = 1'b0; parent_waddr = '0; parent_wdata = '0; parent_raddr = '0;
        letter_we    = 1'b0; letter_waddr = '0; letter_wdata = '0; letter_raddr = '0;
        nwgt_we      = 1'b0; nwgt_waddr   = '0; nwgt_wdata   = '0; nwgt_raddr   = '0;
        wsum_we      = 1'b0; wsum_waddr   = '0; wsum_wdata   = '0; wsum_raddr   = '0;
        bfsq_we      = 1'b0; bfsq_waddr   = '0; bfsq_wdata   = '0; bfsq_raddr   = '0;
        op_next      = op_reg;
        sym_next     = sym_reg;
        wgt_next     = wgt_reg;
        cursor_next  = cursor_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        derived_next = derived_reg;
        root_w_next  = root_w_reg;
        w_next       = w_reg;
        via_next     = via_reg;
        u_next       = u_reg;
        lu_next      = lu_reg;
        c_next       = c_reg;
        rb_head_next = rb_head_reg;
        rb_tail_next = rb_tail_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        node_next    = node_reg;
        mw_next      = mw_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    op_next  = q_item.op;
                    sym_next = q_item.symbol;
                    wgt_next = q_item.weight;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        child_raddr = tab_addr(cursor_reg, sym_reg);
                    end
                    OP_END:
                    begin
                        nwgt_raddr = cursor_reg;
                    end
                    OP_MATCH:
                    begin
                        goto_raddr = tab_addr(match_reg, sym_reg);
                    end
                    OP_INS_REPORT:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        node_next   = cursor_reg;
                        mw_next     = '0;
                    end
                    OP_CLEAR:
                    begin
                        count_next   = COUNT_W'(1);
                        cursor_next  = '0;
                        match_next   = '0;
                        derived_next = 1'b0;
                        root_w_next  = '0;
                        done_next    = 1'b1;
                        status_next  = ST_OK;
                        node_next    = '0;
                        mw_next      = '0;
                    end
                    OP_NOP:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        node_next   = match_reg;
                        mw_next     = '0;
                    end
                    default:
                    begin
                        match_next  = '0;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        node_next   = '0;
                        mw_next     = '0;
                    end
                endcase
            end
            S_INS_VAL:
            begin
                w_next       = child_rdata;
                parent_raddr = child_rdata;
                letter_raddr = child_rdata;
            end
            S_INS_CHK:
            begin
                done_next = 1'b1;
                mw_next   = '0;
                if (ins_hit)
                begin
                    cursor_next = w_reg;
                    status_next = ST_OK;
                    node_next   = w_reg;
                end
                else if (count_reg >= COUNT_W'(MAX_NODES))
                begin
                    status_next = ST_FULL;
                    node_next   = cursor_reg;
                end
                else
                begin
                    child_we     = 1'b1;
                    child_waddr  = tab_addr(cursor_reg, sym_reg);
                    child_wdata  = count_reg[NODE_W-1:0];
                    parent_we    = 1'b1;
                    parent_waddr = count_reg[NODE_W-1:0];
                    parent_wdata = cursor_reg;
                    letter_we    = 1'b1;
                    letter_waddr = count_reg[NODE_W-1:0];
                    letter_wdata = sym_reg;
                    nwgt_we      = 1'b1;
                    nwgt_waddr   = count_reg[NODE_W-1:0];
                    nwgt_wdata   = '0;
                    cursor_next  = count_reg[NODE_W-1:0];
                    count_next   = count_reg + COUNT_W'(1);
                    derived_next = 1'b0;
                    status_next  = ST_OK;
                    node_next    = count_reg[NODE_W-1:0];
                end
            end
            S_END_WR:
            begin
                if (cursor_reg == '0)
                begin
                    root_w_next = end_cl.val;
                end
                else
                begin
                    nwgt_we    = 1'b1;
                    nwgt_waddr = cursor_reg;
                    nwgt_wdata = end_cl.val;
                end
                done_next    = 1'b1;
                status_next  = end_cl.hit ? ST_SAT : ST_OK;
                node_next    = cursor_reg;
                mw_next      = end_cl.val;
                cursor_next  = '0;
                derived_next = 1'b0;
            end
            S_MATCH_SUM:
            begin
                w_next     = goto_rdata;
                wsum_raddr = goto_rdata;
            end
            S_MATCH_OUT:
            begin
                match_next = w_reg;
                done_next  = 1'b1;
                node_next  = w_reg;
                if (w_reg == '0)
                begin
                    status_next = ST_OK;
                    mw_next     = '0;
                end
                else
                begin
                    status_next = wsum_rdata[SUM_W] ? ST_SAT : ST_OK;
                    mw_next     = wsum_rdata[SUM_W-1:0];
                end
            end
            S_RB_INIT:
            begin
                bfsq_we      = 1'b1;
                bfsq_waddr   = '0;
                bfsq_wdata   = '0;
                rb_head_next = '0;
                rb_tail_next = COUNT_W'(1);
            end
            S_RB_POP:
            begin
                if (rb_empty)
                    derived_next = 1'b1;
                else
                    bfsq_raddr = rb_head_reg[NODE_W-1:0];
            end
            S_RB_U:
            begin
                u_next       = bfsq_rdata;
                link_raddr   = bfsq_rdata;
                rb_head_next = rb_head_reg + COUNT_W'(1);
                c_next       = '0;
            end
            S_RB_LU:
            begin
                lu_next = (u_reg == '0) ? '0 : link_rdata;
            end
            S_RB_C:
            begin
                child_raddr = tab_addr(u_reg, c_reg);
                goto_raddr  = tab_addr(lu_reg, c_reg);
            end
            S_RB_W:
            begin
                w_next       = child_rdata;
                via_next     = (u_reg == '0) ? '0 : goto_rdata;
                parent_raddr = child_rdata;
                letter_raddr = child_rdata;
            end
            S_RB_V:
            begin
                if (rb_hit)
                begin
                    nwgt_raddr = w_reg;
                    wsum_raddr = via_reg;
                end
                else
                begin
                    goto_we    = 1'b1;
                    goto_waddr = tab_addr(u_reg, c_reg);
                    goto_wdata = via_reg;
                    c_next     = c_reg + SYM_W'(1);
                end
            end
            S_RB_SUM:
            begin
                wsum_we      = 1'b1;
                wsum_waddr   = w_reg;
                wsum_wdata   = {rb_cl.hit || ((via_reg != '0) && wsum_rdata[SUM_W]),
                                rb_cl.val};
                link_we      = 1'b1;
                link_waddr   = w_reg;
                link_wdata   = via_reg;
                goto_we      = 1'b1;
                goto_waddr   = tab_addr(u_reg, c_reg);
                goto_wdata   = w_reg;
                bfsq_we      = 1'b1;
                bfsq_waddr   = rb_tail_reg[NODE_W-1:0];
                bfsq_wdata   = w_reg;
                rb_tail_next = rb_tail_reg + COUNT_W'(1);
                c_next       = c_reg + SYM_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cursor_reg  <= '0;
            match_reg   <= '0;
            count_reg   <= COUNT_W'(1);
            derived_reg <= 1'b0;
            root_w_reg  <= '0;
            rb_head_reg <= '0;
            rb_tail_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            match_reg   <= match_next;
            count_reg   <= count_next;
            derived_reg <= derived_next;
            root_w_reg  <= root_w_next;
            rb_head_reg <= rb_head_next;
            rb_tail_reg <= rb_tail_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sym_reg    <= sym_next;
        wgt_reg    <= wgt_next;
        w_reg      <= w_next;
        via_reg    <= via_next;
        u_reg      <= u_next;
        lu_reg     <= lu_next;
        c_reg      <= c_next;
        status_reg <= status_next;
        node_reg   <= node_next;
        mw_reg     <= mw_next;
    end

    always_ff @(posedge clk)
    begin
        if (child_we) child_mem[child_waddr] <= child_wdata;
        child_rdata <= child_mem[child_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (goto_we) goto_mem[goto_waddr] <= goto_wdata;
        goto_rdata <= goto_mem[goto_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we) link_mem[link_waddr] <= link_wdata;
        link_rdata <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (parent_we) parent_mem[parent_waddr] <= parent_wdata;
        parent_rdata <= parent_mem[parent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (letter_we) letter_mem[letter_waddr] <= letter_wdata;
        letter_rdata <= letter_mem[letter_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nwgt_we) nwgt_mem[nwgt_waddr] <= nwgt_wdata;
        nwgt_rdata <= nwgt_mem[nwgt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wsum_we) wsum_mem[wsum_waddr] <= wsum_wdata;
        wsum_rdata <= wsum_mem[wsum_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bfsq_we) bfsq_mem[bfsq_waddr] <= bfsq_wdata;
        bfsq_rdata <= bfsq_mem[bfsq_raddr];
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign node         = node_reg;
    assign match_weight = mw_reg;

    `ACM_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, (count_reg >= COUNT_W'(1)) && (count_reg <= COUNT_W'(MAX_NODES)))
    `ACM_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty)
    `ACM_ASSERT_IMP(a_bfs_order, clk, rst_n, 1'b1, rb_head_reg <= rb_tail_reg)
    `ACM_ASSERT_NEXT(a_clear_root, clk, rst_n, (state_reg == S_DECODE) && (op_reg == OP_CLEAR), (count_reg == COUNT_W'(1)) && (cursor_reg == '0) && !derived_reg)

endmodule

FILE: hw/rtl/aho_corasick_matcher_top.sv
// ---------------------------------------------------------------------------
// aho_corasick_matcher_top
// weighted multi-pattern matcher: trie build, lazy automaton rebuild, match
//
// channel   direction  handshake              word
// request   in         start high, busy low   req_type, symbol, weight
// result    out        done strobe, one cycle status, node, match_weight
//
// insert letter runs decode, read and check after the queue, end pattern decode
// and write, other requests decode only; a match on a resolved automaton reads
// goto and weight sum before it reports; after any trie change the first match
// rebuilds it first, per node and letter slot, paced by one read port per table
// reset and clear trie return to the root-only trie with no clearing pass
// a two-word queue lets requests be taken while the back end works
// ---------------------------------------------------------------------------
module aho_corasick_matcher_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        req_type,
    input  logic [acm_pkg::SYM_W-1:0]         symbol,
    input  logic signed [acm_pkg::WGT_W-1:0]  weight,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [acm_pkg::NODE_W-1:0]        node,
    output logic signed [acm_pkg::SUM_W-1:0]  match_weight
);
    import acm_pkg::*;

    q_stat_t q_stat;
    item_t   push_item;
    item_t   head_item;
    logic    push;
    logic    pop;

    acm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .symbol    (symbol),
        .weight    (weight),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    acm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    acm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_item       (head_item),
        .pop          (pop),
        .done         (done),
        .status       (status),
        .node         (node),
        .match_weight (match_weight)
    );

endmodule

FILE: verif/tb_aho_corasick_matcher_top.sv
// ---------------------------------------------------------------------------
// tb_aho_corasick_matcher_top
// self-checking bench for the weighted aho-corasick matcher
//
// each request word accepted on start/busy is fed to a scoreboard that keeps
// its own trie, rebuilds goto entries, suffix links and weight sums on the
// first match after a trie change, and queues the expected result word. every
// done strobe is checked field by field against the oldest queued word.
// phases: short directed requests, then random epochs of pattern building
// followed by text matching
// ---------------------------------------------------------------------------
module tb_aho_corasick_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acm_pkg::*;

    localparam logic [2:0] REQ_RSVD_5 = 3'd5;
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;
    localparam int CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [1:0]               status;
        logic [NODE_W-1:0]        node;
        logic signed [SUM_W-1:0]  weight;
    } match_word_t;

    class trie_scoreboard;
        int unsigned child_of [TAB_DEPTH];
        int unsigned goto_of [TAB_DEPTH];
        int unsigned fail_link [MAX_NODES];
        int          own_weight [MAX_NODES];
        int          chain_sum [MAX_NODES];
        bit          chain_sat [MAX_NODES];
        int unsigned used_nodes;
        int unsigned cursor;
        int unsigned match_at;
        bit          automaton_ok;
        match_word_t expected_words [$];
        int          errors;

        function new();
            errors = 0;
            clear_trie();
        endfunction

        function void clear_trie();
            foreach (child_of[i])
            begin
                child_of[i] = 0;
                goto_of[i] = 0;
            end
            foreach (fail_link[i])
            begin
                fail_link[i] = 0;
                own_weight[i] = 0;
                chain_sum[i] = 0;
                chain_sat[i] = 0;
            end
            used_nodes = 1;
            cursor = 0;
            match_at = 0;
            automaton_ok = 0;
        endfunction

        function int saturate(longint v, output bit hit);
            hit = 0;
            if (v > longint'(32'sh7fffffff))
            begin
                hit = 1;
                return 32'sh7fffffff;
            end
            if (v < -longint'(33'sh080000000))
            begin
                hit = 1;
                return 32'sh80000000;
            end
            return int'(v);
        endfunction

        function void build_automaton();
            int unsigned bfs [$];
            int unsigned u, lu, w, via, pushed;
            bit hit;
            fail_link[0] = 0;
            chain_sum[0] = 0;
            chain_sat[0] = 0;
            bfs.push_back(0);
            pushed = 1;
            while (bfs.size() > 0)
            begin
                u = bfs.pop_front();
                lu = fail_link[u];
                for (int c = 0; c < ALPHABET; c++)
                begin
                    w = child_of[u*ALPHABET + c];
                    via = (u == 0) ? 0 : goto_of[lu*ALPHABET + c];
                    if (w != 0 && w < MAX_NODES && pushed < MAX_NODES)
                    begin
                        fail_link[w] = via;
                        chain_sum[w] = saturate(longint'(own_weight[w]) +
                                                longint'(chain_sum[via]), hit);
                        chain_sat[w] = hit || chain_sat[via];
                        goto_of[u*ALPHABET + c] = w;
                        bfs.push_back(w);
                        pushed++;
                    end
                    else
                    begin
                        goto_of[u*ALPHABET + c] = via;
                    end
                end
            end
            automaton_ok = 1;
        endfunction

        function void note_request(logic [2:0] rq, logic [SYM_W-1:0] sym,
                                   logic signed [WGT_W-1:0] w);
            match_word_t r;
            int unsigned idx, nx;
            bit hit;
            r.status = ST_OK;
            r.node = NODE_W'(match_at);
            r.weight = 0;
            case (rq)
                REQ_INSERT:
                begin
                    if (sym < ALPHABET)
                    begin
                        idx = cursor*ALPHABET + sym;
                        nx = child_of[idx];
                        if (nx != 0)
                            cursor = nx;
                        else if (used_nodes >= MAX_NODES)
                            r.status = ST_FULL;
                        else
                        begin
                            child_of[idx] = used_nodes;
                            cursor = used_nodes;
                            used_nodes++;
                            automaton_ok = 0;
                        end
                    end
                    r.node = NODE_W'(cursor);
                end
                REQ_END:
                begin
                    r.node = NODE_W'(cursor);
                    own_weight[cursor] = saturate(longint'(own_weight[cursor]) +
                                                  longint'(w), hit);
                    if (hit)
                        r.status = ST_SAT;
                    r.weight = own_weight[cursor];
                    cursor = 0;
                    automaton_ok = 0;
                end
                REQ_MATCH:
                begin
                    if (sym < ALPHABET)
                    begin
                        if (!automaton_ok)
                            build_automaton();
                        match_at = goto_of[match_at*ALPHABET + sym];
                        if (match_at >= MAX_NODES)
                            match_at = 0;
                        r.weight = chain_sum[match_at];
                        if (chain_sat[match_at])
                            r.status = ST_SAT;
                    end
                    else
                        match_at = 0;
                    r.node = NODE_W'(match_at);
                end
                REQ_RESTART:
                begin
                    match_at = 0;
                    r.node = 0;
                end
                REQ_CLEAR:
                begin
                    clear_trie();
                    r.node = 0;
                end
                default:
                begin
                end
            endcase
            expected_words.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [NODE_W-1:0] nd,
                                   logic signed [SUM_W-1:0] mw);
            match_word_t e;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: status %0d node %0d weight %0d",
                       st, nd, mw);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (nd !== e.node)
            begin
                $error("node: expected %0d, got %0d", e.node, nd);
                errors++;
            end
            if (mw !== e.weight)
            begin
                $error("match_weight: expected %0d, got %0d", e.weight, mw);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [2:0]                 req_type;
    logic [SYM_W-1:0]           symbol;
    logic signed [WGT_W-1:0]    weight;
    logic                       done;
    logic [1:0]                 status;
    logic [NODE_W-1:0]          node;
    logic signed [SUM_W-1:0]    match_weight;

    trie_scoreboard sb;
    bit             gaps_on;
    int             cycles = 0;

    aho_corasick_matcher_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .symbol       (symbol),
        .weight       (weight),
        .done         (done),
        .status       (status),
        .node         (node),
        .match_weight (match_weight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(status, node, match_weight);

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(logic [2:0] rq, logic [SYM_W-1:0] sym,
                        logic signed [WGT_W-1:0] w);
        int g;
        g = idle_len();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rq;
        symbol <= sym;
        weight <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(rq, sym, w);
    endtask

    function automatic logic [SYM_W-1:0] pick_letter();
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom_range(0, ALPHABET-1));
        return SYM_W'($urandom_range(0, 3));
    endfunction

    function automatic logic signed [WGT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3, 4: return WGT_W'($urandom);
            default: return WGT_W'($urandom_range(0, 40)) - 16'sd20;
        endcase
    endfunction

    task automatic run_epoch();
        int npat, len, ntext, r;
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1))
            send(REQ_CLEAR, pick_letter(), pick_weight());
        npat = $urandom_range(1, 5);
        repeat (npat)
        begin
            len = $urandom_range(1, 4);
            repeat (len)
                send(REQ_INSERT, pick_letter(), pick_weight());
            send(REQ_END, pick_letter(), pick_weight());
        end
        ntext = $urandom_range(15, 40);
        repeat (ntext)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send(REQ_RESTART, pick_letter(), pick_weight());
            else if (r < 9)
                send(3'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 31)),
                     WGT_W'($urandom));
            else
                send(REQ_MATCH, pick_letter(), pick_weight());
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_RESTART;
        symbol = '0;
        weight = '0;
        gaps_on = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        send(REQ_INSERT, 5'd0, 16'sd0);
        send(REQ_INSERT, 5'd25, 16'sd0);
        send(REQ_INSERT, 5'd31, 16'sh7fff);
        send(REQ_END, 5'd31, 16'sh7fff);
        send(REQ_INSERT, 5'd25, 16'sd0);
        send(REQ_END, 5'd0, 16'sh8000);
        send(REQ_END, 5'd0, 16'sd7);
        send(REQ_MATCH, 5'd0, 16'sd0);
        send(REQ_MATCH, 5'd25, 16'sd0);
        send(REQ_MATCH, 5'd31, 16'sh7fff);
        send(REQ_MATCH, 5'd25, 16'sd0);
        send(REQ_RESTART, 5'd31, 16'sh8000);
        send(REQ_RSVD_5, 5'd31, 16'sh7fff);
        send(REQ_RSVD_6, 5'd0, 16'sd0);
        send(REQ_RSVD_7, 5'd31, 16'sh8000);
        send(REQ_INSERT, 5'd1, 16'sd0);
        send(REQ_END, 5'd0, 16'sd1);
        send(REQ_MATCH, 5'd1, 16'sd0);
        send(REQ_CLEAR, 5'd0, 16'sd0);
        send(REQ_MATCH, 5'd0, 16'sd0);

        repeat (30)
            run_epoch();
        start <= 1'b0;

        while (sb.expected_words.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
